// File: rtl/lbct_pkg.sv
package lbct_pkg;

  // Field widths of a request and a result
  localparam int unsigned KeyW  = 64;
  localparam int unsigned LenW  = 32;
  localparam int unsigned HitsW = 32;
  localparam int unsigned SlotW = 4;

  // Hit count saturates here
  localparam logic [HitsW-1:0] HitsMax = {HitsW{1'b1}};
  localparam logic [HitsW-1:0] HitsOne = HitsW'(1);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } lbct_cmd_e;

  // Search token that walks the row of slot cells, one cell per cycle
  typedef struct packed {
    logic             active;     // token present at this point of the row
    lbct_cmd_e        cmd;
    logic             done;       // match or empty slot already taken upstream
    logic             have_best;  // best_hits holds a candidate victim
    logic [HitsW-1:0] best_hits;
    logic [LenW-1:0]  stored_len; // length of the matched slot on a hit
  } lbct_tok_t;

endpackage

// File: rtl/lbct_cell.sv
module lbct_cell #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lbct_pkg::lbct_tok_t        tok_i,
  input  logic [IdxW-1:0]            idx_i,
  input  logic [lbct_pkg::KeyW-1:0]  key_i,
  input  logic [lbct_pkg::LenW-1:0]  len_i,
  input  logic                       wr_en_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  output lbct_pkg::lbct_tok_t        tok_o,
  output logic [IdxW-1:0]            idx_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic                        valid_q;
  logic [lbct_pkg::KeyW-1:0]   key_q;
  logic [lbct_pkg::HitsW-1:0]  hits_q;
  logic [lbct_pkg::LenW-1:0]   len_q;
  lbct_pkg::lbct_tok_t         tok_d, tok_q;
  logic [IdxW-1:0]             idx_d, idx_q;
  logic                        fill;
  logic                        bump;
  logic                        write;

  // Examine this slot as the token passes
  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    fill  = 1'b0;
    bump  = 1'b0;
    if (tok_i.active && !tok_i.done) begin
      if (tok_i.cmd == lbct_pkg::CMD_LOOKUP) begin
        if (valid_q && (key_q == key_i)) begin
          bump             = 1'b1;
          tok_d.done       = 1'b1;
          tok_d.stored_len = len_q;
          idx_d            = MyIdx;
        end
      end else begin
        if (!valid_q) begin
          fill       = 1'b1;
          tok_d.done = 1'b1;
          idx_d      = MyIdx;
        end else if (!tok_i.have_best || (hits_q < tok_i.best_hits)) begin
          tok_d.have_best = 1'b1;
          tok_d.best_hits = hits_q;
          idx_d           = MyIdx;
        end
      end
    end
  end

  assign write = fill || (wr_en_i && (wr_idx_i == MyIdx));

  // Hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // Hold the valid bit of the slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (write) begin
      valid_q <= 1'b1;
    end
  end

  // Update key, length and hit count
  always_ff @(posedge clk_i) begin
    if (write) begin
      key_q  <= key_i;
      len_q  <= len_i;
      hits_q <= lbct_pkg::HitsOne;
    end else if (bump && (hits_q != lbct_pkg::HitsMax)) begin
      hits_q <= hits_q + lbct_pkg::HitsOne;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

// File: rtl/lfu_block_cache_tags_core.sv
// Tag and replacement store of a fully associative block cache with SLOTS
// slots keyed by a 64-bit hash. Each slot is a cell in a row; a request
// token walks the row one cell per cycle, so a lookup hits the lowest
// matching slot and an insert fills the lowest empty slot as it passes. An
// insert that finds no empty slot evicts the lowest-numbered slot with the
// fewest hits, written when the token leaves the row. One request is in
// flight at a time: the token passes through a start register, each cell of
// the row and a finish register before the result reaches the output
// register, and the next request is taken once the previous result has
// moved into the output register. A finished result waits in the output
// register while the next request is accepted. The slot output carries the
// low 4 bits of the slot index.
module lfu_block_cache_tags_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [lbct_pkg::KeyW-1:0]  key_i,
  input  logic [lbct_pkg::LenW-1:0]  entry_length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic [lbct_pkg::SlotW-1:0] slot_o,
  output logic [lbct_pkg::LenW-1:0]  stored_length_o,
  output logic                       evicted_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                        in_accept;
  logic                        busy_q;
  logic                        start_q;
  lbct_pkg::lbct_cmd_e         cmd_q;
  logic [lbct_pkg::KeyW-1:0]   key_q;
  logic [lbct_pkg::LenW-1:0]   len_q;

  lbct_pkg::lbct_tok_t         tok [SLOTS+1];
  logic [IdxW-1:0]             idx [SLOTS+1];

  lbct_pkg::lbct_tok_t         tok_end;
  logic [IdxW-1:0]             idx_end;
  logic                        wr_en;
  logic [IdxW+lbct_pkg::SlotW-1:0] idx_ext;

  logic                        fin_valid_q;
  logic                        fin_hit_q;
  logic [lbct_pkg::SlotW-1:0]  fin_slot_q;
  logic [lbct_pkg::LenW-1:0]   fin_len_q;
  logic                        fin_evict_q;
  logic                        fin_move;

  logic                        out_valid_q;
  logic                        out_hit_q;
  logic [lbct_pkg::SlotW-1:0]  out_slot_q;
  logic [lbct_pkg::LenW-1:0]   out_len_q;
  logic                        out_evict_q;

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;

  // Capture the request and launch its token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= lbct_pkg::lbct_cmd_e'(command_i);
      key_q <= key_i;
      len_q <= entry_length_i;
    end
  end

  // Head of the row
  always_comb begin
    tok[0]            = '0;
    tok[0].active     = start_q;
    tok[0].cmd        = cmd_q;
    idx[0]            = '0;
  end

  // Row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lbct_cell #(
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .idx_i    (idx[g]),
      .key_i    (key_q),
      .len_i    (len_q),
      .wr_en_i  (wr_en),
      .wr_idx_i (idx_end),
      .tok_o    (tok[g+1]),
      .idx_o    (idx[g+1])
    );
  end

  // Tail of the row: evict the least-hit slot when no empty slot was found
  assign tok_end = tok[SLOTS];
  assign idx_end = idx[SLOTS];
  assign wr_en   = tok_end.active && (tok_end.cmd == lbct_pkg::CMD_INSERT) && !tok_end.done;
  assign idx_ext = {{lbct_pkg::SlotW{1'b0}}, idx_end};

  assign fin_move = fin_valid_q && (!out_valid_q || !out_stall_i);

  // Hold the finished result until the output register is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      if (tok_end.active) begin
        fin_valid_q <= 1'b1;
      end else if (fin_move) begin
        fin_valid_q <= 1'b0;
      end
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (fin_move) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end.active) begin
      if (tok_end.cmd == lbct_pkg::CMD_LOOKUP) begin
        fin_hit_q   <= tok_end.done;
        fin_slot_q  <= tok_end.done ? idx_ext[lbct_pkg::SlotW-1:0] : '0;
        fin_len_q   <= tok_end.done ? tok_end.stored_len : '0;
        fin_evict_q <= 1'b0;
      end else begin
        fin_hit_q   <= 1'b0;
        fin_slot_q  <= idx_ext[lbct_pkg::SlotW-1:0];
        fin_len_q   <= '0;
        fin_evict_q <= !tok_end.done;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_move) begin
      out_hit_q   <= fin_hit_q;
      out_slot_q  <= fin_slot_q;
      out_len_q   <= fin_len_q;
      out_evict_q <= fin_evict_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign slot_o          = out_slot_q;
  assign stored_length_o = out_len_q;
  assign evicted_o       = out_evict_q;

endmodule
